>>> src/rs485_reply_deframer_core_assert.svh
// assertion macros used by the deframer core
// each macro expects clk and rst_n in scope
`ifndef RS485_REPLY_DEFRAMER_CORE_ASSERT_SVH
`define RS485_REPLY_DEFRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRD_ASSERT_IMP(lbl, ante, cons, msg)
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/rrd_pkg.sv
package rrd_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES    = 32;
    localparam int KEPT_PAYLOAD_BYTES = 12;
    localparam int OUT_BYTES          = 12;
    localparam int MIN_FRAME          = 5;
    localparam int LEN_W              = $clog2(MAX_FRAME_BYTES + 1);

    // protocol bytes
    localparam logic [7:0] HDR_BYTE   = 8'hAC;
    localparam logic [7:0] BYPASS_CRC = 8'hF5;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // object codes
    localparam logic [7:0] OBJ_RUN_MODE = 8'h01;
    localparam logic [7:0] OBJ_PVC_LO   = 8'h02;
    localparam logic [7:0] OBJ_PVC_HI   = 8'h05;
    localparam logic [7:0] OBJ_TEMP     = 8'h06;
    localparam logic [7:0] OBJ_POS_LIM  = 8'h10;
    localparam logic [7:0] OBJ_VEL_LIM  = 8'h11;
    localparam logic [7:0] OBJ_CUR_LIM  = 8'h12;

    // register map
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_LINEAR_ID  = 2'd0;
    localparam logic [1:0] REG_ROTARY_ID  = 2'd1;
    localparam logic [1:0] REG_CRC_BYPASS = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_DEV,
        PH_OBJ,
        PH_BODY,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_HDR,
        ST_BAD_CRC,
        ST_BAD_LEN
    } status_t;

    typedef enum logic [1:0] {
        DC_LINEAR,
        DC_ROTARY,
        DC_UNKNOWN
    } dev_class_t;

    typedef enum logic [2:0] {
        TS_NONE,
        TS_RUN,
        TS_PVC,
        TS_TEMP,
        TS_POS_LIM,
        TS_VEL_LIM,
        TS_CUR_LIM
    } store_t;

    typedef struct packed {
        logic [7:0] linear_id;
        logic [7:0] rotary_id;
        logic       crc_bypass;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       shift_en;
        logic [7:0] data;
    } cell_ctrl_t;

    typedef struct packed {
        status_t    status;
        dev_class_t device_class;
        logic [7:0] object_code;
        store_t     target_store;
        logic [4:0] payload_length;
        logic [31:0] word_zero;
        logic [31:0] word_one;
        logic [31:0] word_two;
    } res_t;

    // crc-8, msb first, no reflection, no final xor
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // object byte to target store
    function automatic store_t store_of(input logic [7:0] obj);
        store_t s;
        if (obj == OBJ_RUN_MODE)
            s = TS_RUN;
        else if (obj >= OBJ_PVC_LO && obj <= OBJ_PVC_HI)
            s = TS_PVC;
        else if (obj == OBJ_TEMP)
            s = TS_TEMP;
        else if (obj == OBJ_POS_LIM)
            s = TS_POS_LIM;
        else if (obj == OBJ_VEL_LIM)
            s = TS_VEL_LIM;
        else if (obj == OBJ_CUR_LIM)
            s = TS_CUR_LIM;
        else
            s = TS_NONE;
        return s;
    endfunction

endpackage

>>> src/rrd_if.sv
// received byte channel
interface rrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// decoded reply channel
interface rrd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  device_class;
    logic [7:0]  object_code;
    logic [2:0]  target_store;
    logic [4:0]  payload_length;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;

    modport source (output valid, output status, output device_class, output object_code,
                    output target_store, output payload_length, output word_zero,
                    output word_one, output word_two, input ready);
    modport sink   (input valid, input status, input device_class, input object_code,
                    input target_store, input payload_length, input word_zero,
                    input word_one, input word_two, output ready);
endinterface

>>> src/rrd_apb_regs.sv
module rrd_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rrd_pkg::cfg_t                 cfg
);

    rrd_pkg::cfg_t cfg_reg;
    rrd_pkg::cfg_t cfg_next;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rrd_pkg::REG_LINEAR_ID:  cfg_next.linear_id  = pwdata[7:0];
                rrd_pkg::REG_ROTARY_ID:  cfg_next.rotary_id  = pwdata[7:0];
                rrd_pkg::REG_CRC_BYPASS: cfg_next.crc_bypass = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_id  <= 8'd1;
            cfg_reg.rotary_id  <= 8'd2;
            cfg_reg.crc_bypass <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            rrd_pkg::REG_LINEAR_ID:  prdata = {24'd0, cfg_reg.linear_id};
            rrd_pkg::REG_ROTARY_ID:  prdata = {24'd0, cfg_reg.rotary_id};
            rrd_pkg::REG_CRC_BYPASS: prdata = {31'd0, cfg_reg.crc_bypass};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

>>> src/rrd_byte_cell.sv
module rrd_byte_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rrd_pkg::cell_ctrl_t ctrl,
    input  logic                tok_load,
    input  logic                tok_in,
    output logic                tok_out,
    output logic [7:0]          byte_out
);

    logic       tok_reg;
    logic       tok_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // write token walks one cell per payload byte
    always_comb
    begin
        tok_next  = tok_reg;
        data_next = data_reg;
        if (ctrl.clear)
        begin
            tok_next  = tok_load;
            data_next = 8'd0;
        end
        else if (ctrl.shift_en)
        begin
            tok_next = tok_in;
            if (tok_reg)
                data_next = ctrl.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign tok_out  = tok_reg;
    assign byte_out = data_reg;

endmodule

>>> src/rs485_reply_deframer_core.sv
// RS-485 reply deframer: takes one reply byte per cycle (header 0xAC, length, device ID,
// object, payload, CRC-8 poly 0x07) and gives one decoded word per frame end or per header
// or length error. The CRC update is a single combinational step and the payload bytes land
// in a row of byte cells steered by a write token that moves one cell per payload byte.
// Results go through an output register backed by one skid entry, so input is held off
// only while both hold an untaken result. Configuration is an APB-style port: linear
// motor ID at 0x0, rotary motor ID at 0x4, CRC bypass enable at 0x8.
`include "rs485_reply_deframer_core_assert.svh"

module rs485_reply_deframer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    rrd_in_if.sink                         rx_in,
    rrd_out_if.source                      res_out
);

    localparam int LW = rrd_pkg::LEN_W;
    localparam int KB = rrd_pkg::KEPT_PAYLOAD_BYTES;

    rrd_pkg::cfg_t       cfg;
    rrd_pkg::cell_ctrl_t cell_ctrl;
    rrd_pkg::phase_t     phase_reg, phase_next;
    rrd_pkg::phase_t     eff_phase;
    rrd_pkg::res_t       res_c, out_reg, out_next, skid_reg, skid_next;
    rrd_pkg::dev_class_t dev_class;

    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] len_diff;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    dev_reg, dev_next;
    logic [7:0]    obj_reg, obj_next;
    logic [7:0]    b;
    logic [7:0]    crc_upd;
    logic          accept;
    logic          res_valid_c;
    logic          res_fire;
    logic          crc_ok;
    logic          more_body;
    logic          out_vld_reg, out_vld_next;
    logic          skid_vld_reg, skid_vld_next;

    logic [KB:0]   tok;
    logic [7:0]    cell_byte [KB];
    logic [7:0]    pay_byte  [rrd_pkg::OUT_BYTES];

    // configuration registers
    rrd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // row of payload cells
    assign tok[0] = 1'b0;
    for (genvar k = 0; k < KB; k++)
    begin : g_cell
        rrd_byte_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .tok_load (k == 0),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .byte_out (cell_byte[k])
        );
    end

    // bytes past the kept count read as zero
    for (genvar k = 0; k < rrd_pkg::OUT_BYTES; k++)
    begin : g_pay
        if (k < KB)
        begin : g_kept
            assign pay_byte[k] = cell_byte[k];
        end
        else
        begin : g_zero
            assign pay_byte[k] = 8'd0;
        end
    end

    assign accept    = rx_in.valid && rx_in.ready;
    assign b         = rx_in.rx_byte;
    assign eff_phase = rx_in.frame_start ? rrd_pkg::PH_IDLE : phase_reg;
    assign crc_upd   = rrd_pkg::crc8_step(
                           (eff_phase == rrd_pkg::PH_IDLE) ? 8'd0 : crc_reg, b);
    assign more_body = ({1'b0, idx_reg} + (LW+1)'(1)) < {1'b0, len_reg};
    assign crc_ok    = (cfg.crc_bypass && (b == rrd_pkg::BYPASS_CRC)) || (b == crc_reg);
    assign len_diff  = len_reg - LW'(rrd_pkg::MIN_FRAME);

    // device classification, linear wins when both ids match
    always_comb
    begin
        priority if (dev_reg == cfg.linear_id)
            dev_class = rrd_pkg::DC_LINEAR;
        else if (dev_reg == cfg.rotary_id)
            dev_class = rrd_pkg::DC_ROTARY;
        else
            dev_class = rrd_pkg::DC_UNKNOWN;
    end

    // frame sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        dev_next       = dev_reg;
        obj_next       = obj_reg;
        cell_ctrl      = '0;
        cell_ctrl.data = b;
        res_valid_c    = 1'b0;
        res_c          = '0;

        if (accept)
        begin
            unique case (eff_phase)
                rrd_pkg::PH_IDLE:
                begin
                    if (b != rrd_pkg::HDR_BYTE)
                    begin
                        phase_next   = rrd_pkg::PH_DROP;
                        res_valid_c  = 1'b1;
                        res_c.status = rrd_pkg::ST_BAD_HDR;
                    end
                    else
                    begin
                        cell_ctrl.clear = 1'b1;
                        crc_next        = crc_upd;
                        idx_next        = LW'(1);
                        phase_next      = rrd_pkg::PH_LEN;
                    end
                end
                rrd_pkg::PH_LEN:
                begin
                    if (b < 8'(rrd_pkg::MIN_FRAME) || b > 8'(rrd_pkg::MAX_FRAME_BYTES))
                    begin
                        phase_next   = rrd_pkg::PH_DROP;
                        res_valid_c  = 1'b1;
                        res_c.status = rrd_pkg::ST_BAD_LEN;
                    end
                    else
                    begin
                        len_next   = LW'(b);
                        crc_next   = crc_upd;
                        idx_next   = LW'(2);
                        phase_next = rrd_pkg::PH_DEV;
                    end
                end
                rrd_pkg::PH_DEV:
                begin
                    dev_next   = b;
                    crc_next   = crc_upd;
                    idx_next   = LW'(3);
                    phase_next = rrd_pkg::PH_OBJ;
                end
                rrd_pkg::PH_OBJ:
                begin
                    obj_next   = b;
                    crc_next   = crc_upd;
                    idx_next   = LW'(4);
                    phase_next = rrd_pkg::PH_BODY;
                end
                rrd_pkg::PH_BODY:
                begin
                    if (more_body)
                    begin
                        cell_ctrl.shift_en = 1'b1;
                        crc_next           = crc_upd;
                        idx_next           = idx_reg + LW'(1);
                    end
                    else
                    begin
                        // crc byte closes the frame
                        phase_next  = rrd_pkg::PH_IDLE;
                        res_valid_c = 1'b1;
                        if (!crc_ok)
                        begin
                            res_c.status = rrd_pkg::ST_BAD_CRC;
                        end
                        else
                        begin
                            res_c.status         = rrd_pkg::ST_OK;
                            res_c.device_class   = dev_class;
                            res_c.object_code    = obj_reg;
                            res_c.target_store   = (dev_class == rrd_pkg::DC_UNKNOWN) ?
                                                   rrd_pkg::TS_NONE :
                                                   rrd_pkg::store_of(obj_reg);
                            res_c.payload_length = 5'(len_diff);
                            res_c.word_zero = {pay_byte[3], pay_byte[2],
                                               pay_byte[1], pay_byte[0]};
                            res_c.word_one  = {pay_byte[7], pay_byte[6],
                                               pay_byte[5], pay_byte[4]};
                            res_c.word_two  = {pay_byte[11], pay_byte[10],
                                               pay_byte[9], pay_byte[8]};
                        end
                    end
                end
                rrd_pkg::PH_DROP:
                begin
                    phase_next = rrd_pkg::PH_DROP;
                end
                default:
                begin
                    phase_next = rrd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= rrd_pkg::PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // frame context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            len_reg <= '0;
            crc_reg <= 8'd0;
            dev_reg <= 8'd0;
            obj_reg <= 8'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
            dev_reg <= dev_next;
            obj_reg <= obj_next;
        end
    end

    // output register with one skid entry
    assign res_fire    = accept && res_valid_c;
    assign rx_in.ready = !skid_vld_reg;

    always_comb
    begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;

        priority if (skid_vld_reg && res_out.ready)
        begin
            out_next      = skid_reg;
            out_vld_next  = 1'b1;
            skid_vld_next = 1'b0;
        end
        else if (res_fire && (!out_vld_reg || res_out.ready))
        begin
            out_next     = res_c;
            out_vld_next = 1'b1;
        end
        else if (res_fire)
        begin
            skid_next     = res_c;
            skid_vld_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            // stalled, both entries hold
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_out.valid          = out_vld_reg;
    assign res_out.status         = out_reg.status;
    assign res_out.device_class   = out_reg.device_class;
    assign res_out.object_code    = out_reg.object_code;
    assign res_out.target_store   = out_reg.target_store;
    assign res_out.payload_length = out_reg.payload_length;
    assign res_out.word_zero      = out_reg.word_zero;
    assign res_out.word_one       = out_reg.word_one;
    assign res_out.word_two       = out_reg.word_two;

    // checks
    `RRD_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg,
                    "skid entry held while output register empty")
    `RRD_ASSERT_IMP(a_one_write_token, 1'b1, $onehot0(tok),
                    "more than one payload write token")
    `RRD_ASSERT_NEXT(a_frame_end_idle, res_fire && res_c.status == rrd_pkg::ST_OK,
                     phase_reg == rrd_pkg::PH_IDLE, "sequencer not idle after good frame")
    `RRD_ASSERT_IMP(a_error_fields_clear, out_vld_reg && out_reg.status != rrd_pkg::ST_OK,
                    out_reg.word_zero == 32'd0 && out_reg.object_code == 8'd0,
                    "error word carries payload")

endmodule

>>> sim/tb_rs485_reply_deframer_core.sv
module tb_rs485_reply_deframer_core;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int GAP_PERCENT   = 14;

    typedef enum int {
        CRC_GOOD,
        CRC_FORCED,
        CRC_WRONG
    } crc_mode_t;

    // tracks the deframer state and holds the replies it should give
    class reply_tracker;
        logic [7:0]      lin_id;
        logic [7:0]      rot_id;
        logic            bypass;
        rrd_pkg::phase_t phase;
        logic [7:0]      idx;
        logic [7:0]      flen;
        logic [7:0]      crc;
        logic [7:0]      dev;
        logic [7:0]      obj;
        logic [7:0]      kept [rrd_pkg::KEPT_PAYLOAD_BYTES];
        rrd_pkg::res_t   pending_replies [$];
        int              errors;

        function new();
            lin_id = 8'd1;
            rot_id = 8'd2;
            bypass = 1'b1;
            phase  = rrd_pkg::PH_IDLE;
            idx    = '0;
            flen   = '0;
            crc    = '0;
            dev    = '0;
            obj    = '0;
            foreach (kept[i])
                kept[i] = '0;
            errors = 0;
        endfunction

        // crc-8 poly 0x07, msb first
        static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int i = 0; i < 8; i++)
                r = r[7] ? ((r << 1) ^ rrd_pkg::CRC_POLY) : (r << 1);
            return r;
        endfunction

        function rrd_pkg::store_t store_for_object(logic [7:0] o);
            case (o)
                rrd_pkg::OBJ_RUN_MODE: return rrd_pkg::TS_RUN;
                rrd_pkg::OBJ_PVC_LO, rrd_pkg::OBJ_PVC_LO + 8'd1,
                rrd_pkg::OBJ_PVC_LO + 8'd2, rrd_pkg::OBJ_PVC_HI: return rrd_pkg::TS_PVC;
                rrd_pkg::OBJ_TEMP: return rrd_pkg::TS_TEMP;
                rrd_pkg::OBJ_POS_LIM: return rrd_pkg::TS_POS_LIM;
                rrd_pkg::OBJ_VEL_LIM: return rrd_pkg::TS_VEL_LIM;
                rrd_pkg::OBJ_CUR_LIM: return rrd_pkg::TS_CUR_LIM;
                default: return rrd_pkg::TS_NONE;
            endcase
        endfunction

        function logic [31:0] word_from(int base);
            return {kept[base + 3], kept[base + 2], kept[base + 1], kept[base]};
        endfunction

        function void set_reg(logic [1:0] reg_idx, logic [31:0] val);
            case (reg_idx)
                rrd_pkg::REG_LINEAR_ID:  lin_id = val[7:0];
                rrd_pkg::REG_ROTARY_ID:  rot_id = val[7:0];
                rrd_pkg::REG_CRC_BYPASS: bypass = val[0];
                default: ;
            endcase
        endfunction

        // advance on one accepted byte word, queue a reply if one is due
        function void take_byte(logic [7:0] b, logic fs);
            rrd_pkg::res_t r;
            int            p;
            logic [7:0]    diff;
            r = '0;
            if (fs)
                phase = rrd_pkg::PH_IDLE;
            case (phase)
                rrd_pkg::PH_IDLE:
                begin
                    if (b != rrd_pkg::HDR_BYTE)
                    begin
                        phase = rrd_pkg::PH_DROP;
                        r.status = rrd_pkg::ST_BAD_HDR;
                        pending_replies.push_back(r);
                    end
                    else
                    begin
                        foreach (kept[i])
                            kept[i] = '0;
                        crc   = crc_next(8'h00, b);
                        idx   = 8'd1;
                        phase = rrd_pkg::PH_LEN;
                    end
                end
                rrd_pkg::PH_LEN:
                begin
                    if (int'(b) < rrd_pkg::MIN_FRAME || int'(b) > rrd_pkg::MAX_FRAME_BYTES)
                    begin
                        phase = rrd_pkg::PH_DROP;
                        r.status = rrd_pkg::ST_BAD_LEN;
                        pending_replies.push_back(r);
                    end
                    else
                    begin
                        flen  = b;
                        crc   = crc_next(crc, b);
                        idx   = 8'd2;
                        phase = rrd_pkg::PH_DEV;
                    end
                end
                rrd_pkg::PH_DEV:
                begin
                    dev   = b;
                    crc   = crc_next(crc, b);
                    idx   = 8'd3;
                    phase = rrd_pkg::PH_OBJ;
                end
                rrd_pkg::PH_OBJ:
                begin
                    obj   = b;
                    crc   = crc_next(crc, b);
                    idx   = 8'd4;
                    phase = rrd_pkg::PH_BODY;
                end
                rrd_pkg::PH_BODY:
                begin
                    if (int'(idx) + 1 < int'(flen))
                    begin
                        p = int'(idx) - 4;
                        if (p < rrd_pkg::KEPT_PAYLOAD_BYTES)
                            kept[p] = b;
                        crc = crc_next(crc, b);
                        idx = idx + 8'd1;
                    end
                    else
                    begin
                        // crc byte closes the frame
                        phase = rrd_pkg::PH_IDLE;
                        if (!(bypass && b == rrd_pkg::BYPASS_CRC) && b != crc)
                        begin
                            r.status = rrd_pkg::ST_BAD_CRC;
                        end
                        else
                        begin
                            r.status = rrd_pkg::ST_OK;
                            if (dev == lin_id)
                                r.device_class = rrd_pkg::DC_LINEAR;
                            else if (dev == rot_id)
                                r.device_class = rrd_pkg::DC_ROTARY;
                            else
                                r.device_class = rrd_pkg::DC_UNKNOWN;
                            r.object_code  = obj;
                            r.target_store = (r.device_class == rrd_pkg::DC_UNKNOWN) ?
                                             rrd_pkg::TS_NONE : store_for_object(obj);
                            diff = flen - 8'(rrd_pkg::MIN_FRAME);
                            r.payload_length = diff[4:0];
                            r.word_zero = word_from(0);
                            r.word_one  = word_from(4);
                            r.word_two  = word_from(8);
                        end
                        pending_replies.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one reply word with the oldest expectation
        function void compare_reply(rrd_pkg::res_t got);
            rrd_pkg::res_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            check_field("status", want.status, got.status);
            check_field("device_class", want.device_class, got.device_class);
            check_field("object_code", want.object_code, got.object_code);
            check_field("target_store", want.target_store, got.target_store);
            check_field("payload_length", want.payload_length, got.payload_length);
            check_field("word_zero", want.word_zero, got.word_zero);
            check_field("word_one", want.word_one, got.word_one);
            check_field("word_two", want.word_two, got.word_two);
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rrd_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    rrd_in_if  rx_if ();
    rrd_out_if res_if ();

    reply_tracker tracker = new();

    bit gaps_on = 1'b1;
    int hold_req = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    rs485_reply_deframer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx_in   (rx_if),
        .res_out (res_if)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reply side ready, with random gaps and requested hold-offs
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
        end
    end

    // reply word capture
    always @(posedge clk)
    begin : take_reply
        rrd_pkg::res_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.status         = rrd_pkg::status_t'(res_if.status);
            got.device_class   = rrd_pkg::dev_class_t'(res_if.device_class);
            got.object_code    = res_if.object_code;
            got.target_store   = rrd_pkg::store_t'(res_if.target_store);
            got.payload_length = res_if.payload_length;
            got.word_zero      = res_if.word_zero;
            got.word_one       = res_if.word_one;
            got.word_two       = res_if.word_two;
            tracker.compare_reply(got);
        end
    end

    // offer one byte word, starting just after a falling edge
    task automatic send_byte(logic [7:0] b, logic fs);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid       <= 1'b1;
        rx_if.rx_byte     <= b;
        rx_if.frame_start <= fs;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        tracker.take_byte(b, fs);
        bytes_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every expected reply is in
    task automatic wait_for_replies();
        rx_if.valid <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // apb write, setup then access
    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= rrd_pkg::CFG_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(reg_idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one complete frame with random payload
    task automatic send_frame(logic fs, logic [7:0] len, logic [7:0] dev, logic [7:0] obj,
                              crc_mode_t mode);
        logic [7:0] c;
        logic [7:0] pb;
        send_byte(rrd_pkg::HDR_BYTE, fs);
        c = reply_tracker::crc_next(8'h00, rrd_pkg::HDR_BYTE);
        send_byte(len, 1'b0);
        c = reply_tracker::crc_next(c, len);
        send_byte(dev, 1'b0);
        c = reply_tracker::crc_next(c, dev);
        send_byte(obj, 1'b0);
        c = reply_tracker::crc_next(c, obj);
        for (int i = 0; i < int'(len) - rrd_pkg::MIN_FRAME; i++)
        begin
            pb = 8'($urandom_range(255));
            send_byte(pb, 1'b0);
            c = reply_tracker::crc_next(c, pb);
        end
        case (mode)
            CRC_GOOD:   send_byte(c, 1'b0);
            CRC_FORCED: send_byte(rrd_pkg::BYPASS_CRC, 1'b0);
            default:    send_byte(c ^ 8'($urandom_range(1, 255)), 1'b0);
        endcase
    endtask

    // mostly good frames, some bad lengths, truncations and noise
    task automatic random_frame();
        int         kind;
        int         m;
        logic       fs;
        logic [7:0] len;
        logic [7:0] dev;
        logic [7:0] obj;
        crc_mode_t  mode;
        kind = $urandom_range(99);
        fs   = ($urandom_range(3) != 0);
        if (kind < 72)
        begin
            len = ($urandom_range(9) == 0) ? 8'(rrd_pkg::MAX_FRAME_BYTES) :
                  8'($urandom_range(rrd_pkg::MIN_FRAME, 20));
            m = $urandom_range(9);
            if (m < 4)
                dev = tracker.lin_id;
            else if (m < 7)
                dev = tracker.rot_id;
            else
                dev = 8'($urandom_range(255));
            case ($urandom_range(10))
                0: obj = rrd_pkg::OBJ_RUN_MODE;
                1: obj = rrd_pkg::OBJ_PVC_LO;
                2: obj = rrd_pkg::OBJ_PVC_LO + 8'd1;
                3: obj = rrd_pkg::OBJ_PVC_LO + 8'd2;
                4: obj = rrd_pkg::OBJ_PVC_HI;
                5: obj = rrd_pkg::OBJ_TEMP;
                6: obj = rrd_pkg::OBJ_POS_LIM;
                7: obj = rrd_pkg::OBJ_VEL_LIM;
                8: obj = rrd_pkg::OBJ_CUR_LIM;
                default: obj = 8'($urandom_range(255));
            endcase
            m = $urandom_range(9);
            mode = (m < 8) ? CRC_GOOD : (m == 8) ? CRC_FORCED : CRC_WRONG;
            send_frame(fs, len, dev, obj, mode);
        end
        else if (kind < 82)
        begin
            // out of range length, then a few dropped bytes
            send_byte(rrd_pkg::HDR_BYTE, fs);
            len = $urandom_range(1) ? 8'($urandom_range(0, rrd_pkg::MIN_FRAME - 1)) :
                  8'($urandom_range(rrd_pkg::MAX_FRAME_BYTES + 1, 255));
            send_byte(len, 1'b0);
            m = $urandom_range(3);
            for (int i = 0; i < m; i++)
                send_byte(8'($urandom_range(255)), 1'b0);
        end
        else if (kind < 90)
        begin
            // frame cut short before its crc byte
            send_byte(rrd_pkg::HDR_BYTE, fs);
            len = 8'($urandom_range(rrd_pkg::MIN_FRAME, rrd_pkg::MAX_FRAME_BYTES));
            send_byte(len, 1'b0);
            m = $urandom_range(0, int'(len) - 3);
            for (int i = 0; i < m; i++)
                send_byte(8'($urandom_range(255)), 1'b0);
        end
        else
        begin
            m = $urandom_range(1, 4);
            for (int i = 0; i < m; i++)
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_traffic(int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
            random_frame();
    endtask

    initial
    begin
        logic [7:0] b;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = '0;
        rx_if.frame_start = 1'b0;
        res_if.ready      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle byte as bad header, dropped byte, bad lengths,
        // abandoned frame, good frame, bypassed crc, crc mismatch
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(rrd_pkg::HDR_BYTE, 1'b1);
        send_byte(8'(rrd_pkg::MIN_FRAME - 1), 1'b0);
        send_byte(rrd_pkg::HDR_BYTE, 1'b1);
        send_byte(8'(rrd_pkg::MAX_FRAME_BYTES + 1), 1'b0);
        send_byte(rrd_pkg::HDR_BYTE, 1'b1);
        send_byte(8'd9, 1'b0);
        send_frame(1'b1, 8'(rrd_pkg::MIN_FRAME), 8'd1, rrd_pkg::OBJ_RUN_MODE, CRC_GOOD);
        send_frame(1'b0, 8'(rrd_pkg::MIN_FRAME), 8'd2, rrd_pkg::OBJ_TEMP, CRC_FORCED);
        send_frame(1'b1, 8'(rrd_pkg::MIN_FRAME + 1), 8'd3, rrd_pkg::OBJ_POS_LIM, CRC_WRONG);
        wait_for_replies();

        // reset settings
        run_traffic(250);
        wait_for_replies();

        // extreme ids, bypass off, no gaps on either side
        write_reg(rrd_pkg::REG_LINEAR_ID, 32'h0000_0000);
        write_reg(rrd_pkg::REG_ROTARY_ID, 32'h0000_00FF);
        write_reg(rrd_pkg::REG_CRC_BYPASS, 32'h0000_0000);
        gaps_on = 1'b0;
        run_traffic(250);
        wait_for_replies();
        gaps_on = 1'b1;

        // equal ids; reply side held off while header errors pile up
        write_reg(rrd_pkg::REG_LINEAR_ID, 32'h0000_00FF);
        write_reg(rrd_pkg::REG_CRC_BYPASS, 32'h0000_0001);
        hold_req = 200;
        for (int i = 0; i < 16; i++)
        begin
            b = 8'($urandom_range(255));
            if (b == rrd_pkg::HDR_BYTE)
                b = ~b;
            send_byte(b, 1'b1);
        end
        run_traffic(250);
        wait_for_replies();

        // random linear id, rotary id zero, random bypass
        write_reg(rrd_pkg::REG_LINEAR_ID, 32'($urandom_range(255)));
        write_reg(rrd_pkg::REG_ROTARY_ID, 32'h0000_0000);
        write_reg(rrd_pkg::REG_CRC_BYPASS, 32'($urandom_range(1)));
        run_traffic(200);
        wait_for_replies();
        run_traffic(200);
        wait_for_replies();

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/rrd_pkg.sv
src/rrd_if.sv
src/rrd_apb_regs.sv
src/rrd_byte_cell.sv
src/rs485_reply_deframer_core.sv
sim/tb_rs485_reply_deframer_core.sv
